// ===== src/lsepg_pkg.sv =====
// ----------------------------------------------------------------------------
// LED strip effect package
// Shared payload types, register indexes, effect codes and fixed-point
// constants of the LED strip pixel generator.
// ----------------------------------------------------------------------------
package lsepg_pkg;

  typedef struct packed {
    logic       action;
    logic [6:0] pixel_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } out_item_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_EFFECT_MODE = 3'd0;
  localparam logic [2:0] REG_BASE_RED    = 3'd1;
  localparam logic [2:0] REG_BASE_GREEN  = 3'd2;
  localparam logic [2:0] REG_BASE_BLUE   = 3'd3;
  localparam logic [2:0] REG_HUE_SPACING = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  // Effect codes.
  localparam logic [1:0] MODE_BLINK   = 2'd0;
  localparam logic [1:0] MODE_BREATH  = 2'd1;
  localparam logic [1:0] MODE_CYCLE   = 2'd2;
  localparam logic [1:0] MODE_RAINBOW = 2'd3;

  // Action codes.
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Hue arithmetic, tenths of a degree.
  localparam int HUE_ACC_W = 17;
  localparam int RED_STEPS = 5;
  localparam logic [HUE_ACC_W-1:0] HUE_FULL = 17'd3600;
  localparam logic [11:0] HUE_FULL12  = 12'd3600;
  localparam logic [11:0] HUE_SECTOR  = 12'd600;
  localparam logic [11:0] HUE_PAIR    = 12'd1200;
  localparam logic [7:0]  PEAK_LEVEL  = 8'd204;

  // floor(17*d/50) as (d * 17 * 20972) >> 20, exact for d up to 600.
  localparam logic [18:0] HUE_X_MUL = 19'd356524;
  // floor(n/100) as (n * 41944) >> 22, exact for n up to 25500.
  localparam logic [15:0] PCT_MUL   = 16'd41944;

  localparam logic [6:0] BREATH_MIN = 7'd2;
  localparam logic [6:0] BREATH_LOW = 7'd3;
  localparam logic [6:0] BREATH_MAX = 7'd100;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic       load;
    logic       tick;
    logic       reduce;
    logic [2:0] shift;
    logic       sector;
    logic       finish;
  } dp_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic query;
  } dp_status_t;

endpackage

// ===== src/lsepg_ctrl.sv =====
// ----------------------------------------------------------------------------
// LED strip effect sequencer
// Steps a query through load, hue reduction, sector decode and output load,
// a tick through load and output load; owns the valid and stall handshakes.
// ----------------------------------------------------------------------------
module lsepg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  lsepg_pkg::dp_status_t status,
  output lsepg_pkg::dp_cmd_t   cmd
);
  import lsepg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_REDUCE = 4'b0010,
    ST_SECTOR = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.shift     = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.load = 1'b1;
          if (status.query == ACT_QUERY) begin
            step_nxt  = 3'(RED_STEPS - 1);
            state_nxt = ST_REDUCE;
          end else begin
            cmd.tick  = 1'b1;
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        if (step_r == 3'd0) begin
          state_nxt = ST_SECTOR;
        end else begin
          step_nxt = step_r - 3'd1;
        end
      end
      ST_SECTOR: begin
        cmd.sector = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        // The output register is free once its beat has gone or is going now.
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/lsepg_dp.sv =====
// ----------------------------------------------------------------------------
// LED strip effect datapath
// Configuration registers, effect state, hue reduction, hue to RGB mapping,
// breath scaling and the output register.
// ----------------------------------------------------------------------------
module lsepg_dp #(
  parameter int MAX_PIXELS = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lsepg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lsepg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  lsepg_pkg::in_item_t               in_data,
  output lsepg_pkg::out_item_t              out_data,
  input  lsepg_pkg::dp_cmd_t                cmd,
  output lsepg_pkg::dp_status_t             status
);
  import lsepg_pkg::*;

  localparam logic [10:0] MaxPix = 11'(MAX_PIXELS);

  // Configuration.
  logic [1:0] effect_mode_r;
  logic [7:0] base_red_r, base_green_r, base_blue_r;
  logic [8:0] hue_spacing_r;

  // Effect state.
  logic       blink_on_r, blink_on_nxt;
  logic [6:0] breath_level_r, breath_level_nxt;
  logic       breath_rising_r, breath_rising_nxt;
  logic [11:0] cycle_hue_r, cycle_hue_nxt;
  logic [11:0] flow_offset_r, flow_offset_nxt;

  // Per-beat working registers.
  logic                 query_r, in_range_r;
  logic [HUE_ACC_W-1:0] hue_acc_r, hue_acc_nxt;
  logic [14:0]          bprod_r [3];
  logic [7:0]           bch_r [3];
  logic [2:0]           sector_r;
  logic [9:0]           d_r;
  out_item_t            out_data_r, out_data_nxt;

  logic [15:0]          flow_prod;
  logic [HUE_ACC_W-1:0] red_step;
  logic [11:0]          hue, t_val, pair_base;
  logic [2:0]           sector_c;
  logic [9:0]           d_c;
  logic [30:0]          pct_prod [3];
  logic [28:0]          x_prod;
  logic [7:0]           x_lvl;
  logic [7:0]           base_ch [3];

  assign status.query = in_data.action;
  assign out_data     = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_mode_r <= MODE_BLINK;
      base_red_r    <= '0;
      base_green_r  <= '0;
      base_blue_r   <= '0;
      hue_spacing_r <= 9'd36;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EFFECT_MODE: effect_mode_r <= cfg_data[1:0];
        REG_BASE_RED:    base_red_r    <= cfg_data[7:0];
        REG_BASE_GREEN:  base_green_r  <= cfg_data[7:0];
        REG_BASE_BLUE:   base_blue_r   <= cfg_data[7:0];
        REG_HUE_SPACING: hue_spacing_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame tick: only the selected effect moves.
  always_comb begin
    blink_on_nxt      = blink_on_r;
    breath_level_nxt  = breath_level_r;
    breath_rising_nxt = breath_rising_r;
    cycle_hue_nxt     = cycle_hue_r;
    flow_offset_nxt   = flow_offset_r;
    if (cmd.tick) begin
      case (effect_mode_r)
        MODE_BLINK: begin
          blink_on_nxt = !blink_on_r;
        end
        MODE_BREATH: begin
          if (breath_rising_r) begin
            if (breath_level_r + 7'd1 >= BREATH_MAX) begin
              breath_level_nxt  = BREATH_MAX;
              breath_rising_nxt = 1'b0;
            end else begin
              breath_level_nxt = breath_level_r + 7'd1;
            end
          end else if (breath_level_r <= BREATH_LOW) begin
            breath_level_nxt  = BREATH_MIN;
            breath_rising_nxt = 1'b1;
          end else begin
            breath_level_nxt = breath_level_r - 7'd1;
          end
        end
        MODE_CYCLE: begin
          if (cycle_hue_r + 12'd5 >= HUE_FULL12) begin
            cycle_hue_nxt = '0;
          end else begin
            cycle_hue_nxt = cycle_hue_r + 12'd5;
          end
        end
        default: begin
          if (flow_offset_r + 12'd10 >= HUE_FULL12) begin
            flow_offset_nxt = '0;
          end else begin
            flow_offset_nxt = flow_offset_r + 12'd10;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_on_r      <= 1'b0;
      breath_level_r  <= BREATH_MIN;
      breath_rising_r <= 1'b1;
      cycle_hue_r     <= '0;
      flow_offset_r   <= 12'd3590;
    end else begin
      blink_on_r      <= blink_on_nxt;
      breath_level_r  <= breath_level_nxt;
      breath_rising_r <= breath_rising_nxt;
      cycle_hue_r     <= cycle_hue_nxt;
      flow_offset_r   <= flow_offset_nxt;
    end
  end

  // Hue accumulator: loaded at accept, then reduced below 3600 by
  // conditional subtraction of 3600 times 16, 8, 4, 2 and 1.
  always_comb begin
    flow_prod   = 16'(in_data.pixel_index) * 16'(hue_spacing_r);
    red_step    = HUE_FULL << cmd.shift;
    hue_acc_nxt = hue_acc_r;
    if (cmd.load) begin
      if (effect_mode_r == MODE_RAINBOW) begin
        hue_acc_nxt = 17'(flow_offset_r) + 17'(flow_prod);
      end else begin
        hue_acc_nxt = 17'(cycle_hue_r);
      end
    end else if (cmd.reduce && (hue_acc_r >= red_step)) begin
      hue_acc_nxt = hue_acc_r - red_step;
    end
  end

  // Sector decode and triangle distance from the nearest primary.
  always_comb begin
    hue = hue_acc_r[11:0];
    if (hue >= 12'd3000) begin
      sector_c = 3'd5;
    end else if (hue >= 12'd2400) begin
      sector_c = 3'd4;
    end else if (hue >= 12'd1800) begin
      sector_c = 3'd3;
    end else if (hue >= 12'd1200) begin
      sector_c = 3'd2;
    end else if (hue >= HUE_SECTOR) begin
      sector_c = 3'd1;
    end else begin
      sector_c = 3'd0;
    end
    case (sector_c[2:1])
      2'd0:    pair_base = 12'd0;
      2'd1:    pair_base = HUE_PAIR;
      default: pair_base = 12'd2400;
    endcase
    t_val = hue - pair_base;
    if (t_val < HUE_SECTOR) begin
      d_c = t_val[9:0];
    end else begin
      d_c = 10'(HUE_PAIR - t_val);
    end
  end

  always_comb begin
    base_ch[0] = base_red_r;
    base_ch[1] = base_green_r;
    base_ch[2] = base_blue_r;
    for (int i = 0; i < 3; i++) begin
      pct_prod[i] = 31'(bprod_r[i]) * 31'(PCT_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      query_r    <= in_data.action;
      in_range_r <= 11'(in_data.pixel_index) < MaxPix;
      for (int i = 0; i < 3; i++) begin
        bprod_r[i] <= 15'(base_ch[i]) * 15'(breath_level_r);
      end
    end
    hue_acc_r <= hue_acc_nxt;
    if (cmd.sector) begin
      sector_r <= sector_c;
      d_r      <= d_c;
      for (int i = 0; i < 3; i++) begin
        bch_r[i] <= pct_prod[i][29:22];
      end
    end
  end

  // Colour of the pixel, registered into the output stage.
  always_comb begin
    x_prod       = 29'(d_r) * 29'(HUE_X_MUL);
    x_lvl        = x_prod[27:20];
    out_data_nxt = '0;
    if ((query_r == ACT_QUERY) && in_range_r) begin
      case (effect_mode_r)
        MODE_BLINK: begin
          if (blink_on_r) begin
            out_data_nxt = '{base_red_r, base_green_r, base_blue_r};
          end
        end
        MODE_BREATH: begin
          out_data_nxt = '{bch_r[0], bch_r[1], bch_r[2]};
        end
        default: begin
          case (sector_r)
            3'd0:    out_data_nxt = '{PEAK_LEVEL, x_lvl, 8'd0};
            3'd1:    out_data_nxt = '{x_lvl, PEAK_LEVEL, 8'd0};
            3'd2:    out_data_nxt = '{8'd0, PEAK_LEVEL, x_lvl};
            3'd3:    out_data_nxt = '{8'd0, x_lvl, PEAK_LEVEL};
            3'd4:    out_data_nxt = '{x_lvl, 8'd0, PEAK_LEVEL};
            default: out_data_nxt = '{PEAK_LEVEL, 8'd0, x_lvl};
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== src/led_strip_effect_pixel_generator.sv =====
// ----------------------------------------------------------------------------
// LED strip effect pixel generator
// Blink, breath, colour-cycle and rainbow-flow effects for an LED strip.
// ----------------------------------------------------------------------------
// Each input beat is either a frame tick (action 0), which advances the
// selected effect by one frame and returns a black beat, or a pixel query
// (action 1), which returns the RGB drive of pixel pixel_index. Both channels
// use valid and stall; a beat moves when valid is high and stall is low.
// Configuration is to be written by the user through cfg_we, cfg_index and
// cfg_data while the block is idle; the block itself does not enforce this.
// Effect state is never cleared by a mode change. A query loads the hue,
// reduces it modulo 3600 in five steps of shared conditional subtraction,
// decodes the colour sector and forms the channels; a tick goes from load
// straight to the output. A new beat is accepted in the cycle after the
// previous one reaches the output register, so no beat is taken while
// another is in work. The output register parts the channels: the next
// beat is taken while a result waits, and a stalled result holds until it
// is taken, with the next one waiting inside the block. Reset (rst_n low,
// synchronous) empties both channels and restores the configuration
// registers and effect state to their defaults.
module led_strip_effect_pixel_generator #(
  parameter int MAX_PIXELS = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lsepg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lsepg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lsepg_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lsepg_pkg::out_item_t              out_data
);
  import lsepg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  lsepg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lsepg_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
